>>> sv/sscond_pkg.sv
// Shared widths, reset values, register indexes and sequencer states of the sampling conditioner
`default_nettype none

package sscond_pkg;

   localparam int unsigned TIME_W     = 32;
   localparam int unsigned GAS_W      = 12;
   localparam int unsigned HUM_W      = 10;
   localparam int unsigned TEMP_W     = 12;
   localparam int unsigned MEAN_W     = 16;
   localparam int unsigned FRAC_W     = 4;
   localparam int unsigned IVAL_W     = 16;
   localparam int unsigned DEB_W      = 8;
   localparam int unsigned POS_W      = 5;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 4;

   localparam int unsigned WINDOW_DEFAULT = 8;

   localparam logic [IVAL_W-1:0] GAS_IVAL_RESET   = 16'd200;
   localparam logic [IVAL_W-1:0] CLIM_IVAL_RESET  = 16'd2000;
   localparam logic [IVAL_W-1:0] FLAME_IVAL_RESET = 16'd20;
   localparam logic [DEB_W-1:0]  DEBOUNCE_RESET   = 8'd3;
   localparam logic [DEB_W-1:0]  RUN_MAX          = 8'hFF;

   localparam logic FLAME_ACTIVE_LEVEL = 1'b0;

   localparam int unsigned GATE_GAS   = 0;
   localparam int unsigned GATE_CLIM  = 1;
   localparam int unsigned GATE_FLAME = 2;
   localparam int unsigned GATE_N     = 3;

   typedef enum logic [1:0] {
      CSR_GAS_IVAL   = 2'd0,
      CSR_CLIM_IVAL  = 2'd1,
      CSR_FLAME_IVAL = 2'd2,
      CSR_DEBOUNCE   = 2'd3
   } sscond_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_UPD,
      ST_DIV,
      ST_DONE
   } sscond_state_type;

endpackage

`default_nettype wire

>>> sv/sscond_if.sv
// Poll and result channel interfaces of the sampling conditioner
`default_nettype none

interface sscond_req_if
   import sscond_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic [TIME_W-1:0]        now_ms;
   logic [GAS_W-1:0]         gas_sample;
   logic                     flame_pin_level;
   logic                     climate_ok;
   logic [HUM_W-1:0]         humidity_tenths;
   logic signed [TEMP_W-1:0] temperature_tenths;

   modport source (
      output valid, now_ms, gas_sample, flame_pin_level, climate_ok,
             humidity_tenths, temperature_tenths,
      input  ready
   );

   modport sink (
      input  valid, now_ms, gas_sample, flame_pin_level, climate_ok,
             humidity_tenths, temperature_tenths,
      output ready
   );
endinterface

interface sscond_rsp_if
   import sscond_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic                     gas_sampled;
   logic [GAS_W-1:0]         gas_raw;
   logic [MEAN_W-1:0]        gas_average;
   logic                     flame_sampled;
   logic                     flame_raw;
   logic                     flame_stable;
   logic                     flame_changed;
   logic                     climate_attempted;
   logic                     climate_failed;
   logic                     climate_usable;
   logic [HUM_W-1:0]         humidity_out;
   logic signed [TEMP_W-1:0] temperature_out;

   modport source (
      output valid, gas_sampled, gas_raw, gas_average, flame_sampled, flame_raw,
             flame_stable, flame_changed, climate_attempted, climate_failed,
             climate_usable, humidity_out, temperature_out,
      input  ready
   );

   modport sink (
      input  valid, gas_sampled, gas_raw, gas_average, flame_sampled, flame_raw,
             flame_stable, flame_changed, climate_attempted, climate_failed,
             climate_usable, humidity_out, temperature_out,
      output ready
   );
endinterface

`default_nettype wire

>>> sv/sensor_sampling_conditioner_core.sv
// Sampling conditioner core: serial interval gates, gas window mean, flame debounce, climate hold
//
//   channel  dir  handshake              beat
//   req_ch   in   valid/ready            one poll: time, gas, flame pin, climate
//   rsp_ch   out  valid/ready            one conditioned result per poll
//   csr_*    in   psel/penable/pwrite    one register write or read, pready tied high
//
// A poll runs a bit-serial subtract and compare of the three gates over 32 bits,
// then, when the gas gate fires, a restoring divider producing one quotient bit a
// cycle, and then loads the result register once it is free. Synchronous reset
// clears all control and held state.
// A stalled result holds in its register while the next poll is taken and worked.
`default_nettype none

module sensor_sampling_conditioner_core
   import sscond_pkg::*;
#(
   parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   sscond_req_if.sink                 req_ch,
   sscond_rsp_if.source               rsp_ch,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int unsigned SLOTW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int unsigned FILLW = $clog2(WINDOW + 1);
   localparam int unsigned SUMW  = GAS_W + SLOTW;
   localparam int unsigned NUMW  = SUMW + FRAC_W;
   localparam int unsigned DCNTW = $clog2(NUMW);
   localparam logic [SLOTW-1:0] SLOT_LAST = SLOTW'(WINDOW - 1);
   localparam logic [FILLW-1:0] FILL_FULL = FILLW'(WINDOW);
   localparam logic [POS_W-1:0] POS_LAST  = POS_W'(TIME_W - 1);
   localparam logic [DCNTW-1:0] DCNT_LOAD = DCNTW'(NUMW - 1);

   // configuration
   logic [IVAL_W-1:0] gas_ival_ff, clim_ival_ff, flame_ival_ff;
   logic [DEB_W-1:0]  debounce_ff;
   logic              csr_wr;
   sscond_csr_type    csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = sscond_csr_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         gas_ival_ff   <= GAS_IVAL_RESET;
         clim_ival_ff  <= CLIM_IVAL_RESET;
         flame_ival_ff <= FLAME_IVAL_RESET;
         debounce_ff   <= DEBOUNCE_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_GAS_IVAL:   gas_ival_ff   <= csr_pwdata[IVAL_W-1:0];
            CSR_CLIM_IVAL:  clim_ival_ff  <= csr_pwdata[IVAL_W-1:0];
            CSR_FLAME_IVAL: flame_ival_ff <= csr_pwdata[IVAL_W-1:0];
            CSR_DEBOUNCE:   debounce_ff   <= csr_pwdata[DEB_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_GAS_IVAL:   csr_prdata = CSR_DATA_W'(gas_ival_ff);
         CSR_CLIM_IVAL:  csr_prdata = CSR_DATA_W'(clim_ival_ff);
         CSR_FLAME_IVAL: csr_prdata = CSR_DATA_W'(flame_ival_ff);
         CSR_DEBOUNCE:   csr_prdata = CSR_DATA_W'(debounce_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // sequencer
   sscond_state_type state_ff, state_in;
   logic [POS_W-1:0] pos_ff;
   logic [DCNTW-1:0] dcnt_ff;
   logic             rsp_valid_ff;
   logic             req_take, rsp_load;
   logic [GATE_N-1:0] fire;

   assign req_take = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_take) state_in = ST_CMP;
         ST_CMP:  if (pos_ff == POS_LAST) state_in = ST_UPD;
         ST_UPD:  state_in = fire[GATE_GAS] ? ST_DIV : ST_DONE;
         ST_DIV:  if (dcnt_ff == '0) state_in = ST_DONE;
         ST_DONE: if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: req_ch.ready = 1'b1;
         ST_DONE: rsp_load     = !rsp_valid_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: pos_ff  <= '0;
            ST_CMP:  pos_ff  <= pos_ff + POS_W'(1);
            ST_UPD:  dcnt_ff <= DCNT_LOAD;
            ST_DIV:  dcnt_ff <= dcnt_ff - DCNTW'(1);
            default: ;
         endcase
      end
   end

   // captured poll
   logic [TIME_W-1:0]        now_sh_ff;
   logic [GAS_W-1:0]         gas_ff;
   logic                     pin_ff, cok_ff;
   logic [HUM_W-1:0]         hum_ff;
   logic signed [TEMP_W-1:0] tmp_ff;

   // serial gates
   logic [GATE_N-1:0][TIME_W-1:0] last_ff;
   logic [GATE_N-1:0][IVAL_W-1:0] ival;
   logic [GATE_N-1:0] sub_b_ff, sub_b_in, cmp_b_ff, cmp_b_in, nz_ff, nz_in;
   logic [GATE_N-1:0] diff_bit, ival_bit, last_bit;
   logic              now_bit;

   assign ival[GATE_GAS]   = gas_ival_ff;
   assign ival[GATE_CLIM]  = clim_ival_ff;
   assign ival[GATE_FLAME] = flame_ival_ff;
   assign now_bit          = now_sh_ff[0];

   always_comb begin
      for (int g = 0; g < GATE_N; g++) begin
         last_bit[g] = last_ff[g][0];
         ival_bit[g] = ival[g][pos_ff[3:0]] & ~pos_ff[4];
         diff_bit[g] = now_bit ^ last_bit[g] ^ sub_b_ff[g];
         sub_b_in[g] = (~now_bit & last_bit[g]) | (~(now_bit ^ last_bit[g]) & sub_b_ff[g]);
         cmp_b_in[g] = (~diff_bit[g] & ival_bit[g]) |
                       (~(diff_bit[g] ^ ival_bit[g]) & cmp_b_ff[g]);
         nz_in[g]    = nz_ff[g] | last_bit[g];
         fire[g]     = ~nz_ff[g] | ~cmp_b_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_take) begin
         now_sh_ff <= req_ch.now_ms;
         gas_ff    <= req_ch.gas_sample;
         pin_ff    <= req_ch.flame_pin_level;
         cok_ff    <= req_ch.climate_ok;
         hum_ff    <= req_ch.humidity_tenths;
         tmp_ff    <= req_ch.temperature_tenths;
      end else if (state_ff == ST_CMP) begin
         now_sh_ff <= {now_bit, now_sh_ff[TIME_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         sub_b_ff <= '0;
         cmp_b_ff <= '0;
         nz_ff    <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               sub_b_ff <= '0;
               cmp_b_ff <= '0;
               nz_ff    <= '0;
            end
            ST_CMP: begin
               sub_b_ff <= sub_b_in;
               cmp_b_ff <= cmp_b_in;
               nz_ff    <= nz_in;
               for (int g = 0; g < GATE_N; g++) begin
                  last_ff[g] <= {last_bit[g], last_ff[g][TIME_W-1:1]};
               end
            end
            ST_UPD: begin
               for (int g = 0; g < GATE_N; g++) begin
                  if (fire[g]) last_ff[g] <= now_sh_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // gas window
   logic [GAS_W-1:0] win_mem [WINDOW];
   logic [GAS_W-1:0] win_rd_ff;
   logic [SUMW-1:0]  sum_ff, sum_in;
   logic [FILLW-1:0] fill_ff, fill_in;
   logic [SLOTW-1:0] slot_ff, slot_in;
   logic [GAS_W-1:0] gas_raw_ff;
   logic [MEAN_W-1:0] mean_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_UPD && fire[GATE_GAS]) win_mem[slot_ff] <= gas_ff;
      win_rd_ff <= win_mem[slot_ff];
   end

   always_comb begin
      if (fill_ff != FILL_FULL) begin
         sum_in  = sum_ff + SUMW'(gas_ff);
         fill_in = fill_ff + FILLW'(1);
      end else begin
         sum_in  = sum_ff - SUMW'(win_rd_ff) + SUMW'(gas_ff);
         fill_in = fill_ff;
      end
      slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOTW'(1);
   end

   // restoring divider, one quotient bit a cycle
   logic [NUMW-1:0]  num_ff, quo_ff, quo_in;
   logic [FILLW-1:0] rem_ff, rem_in;
   logic [FILLW:0]   trial;
   logic             q_bit;

   always_comb begin
      trial  = {rem_ff, num_ff[NUMW-1]};
      q_bit  = trial >= {1'b0, fill_ff};
      rem_in = q_bit ? FILLW'(trial - {1'b0, fill_ff}) : trial[FILLW-1:0];
      quo_in = {quo_ff[NUMW-2:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         fill_ff    <= '0;
         slot_ff    <= '0;
         gas_raw_ff <= '0;
         mean_ff    <= '0;
      end else begin
         if (state_ff == ST_UPD && fire[GATE_GAS]) begin
            sum_ff     <= sum_in;
            fill_ff    <= fill_in;
            slot_ff    <= slot_in;
            gas_raw_ff <= gas_ff;
         end
         if (state_ff == ST_DIV && dcnt_ff == '0) mean_ff <= quo_in[MEAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_UPD: begin
            num_ff <= {sum_in, {FRAC_W{1'b0}}};
            rem_ff <= '0;
            quo_ff <= '0;
         end
         ST_DIV: begin
            num_ff <= {num_ff[NUMW-2:0], 1'b0};
            rem_ff <= rem_in;
            quo_ff <= quo_in;
         end
         default: ;
      endcase
   end

   // flame debounce
   logic             flame_raw_ff, stable_ff, stable_in, pending_ff, pending_in, changed_in;
   logic [DEB_W-1:0] run_ff, run_in, run_step;
   logic             det;

   always_comb begin
      det        = (pin_ff == FLAME_ACTIVE_LEVEL);
      run_step   = (det != pending_ff) ? DEB_W'(1) :
                   (run_ff != RUN_MAX) ? run_ff + DEB_W'(1) : run_ff;
      pending_in = det;
      stable_in  = stable_ff;
      changed_in = 1'b0;
      run_in     = '0;
      if (det != stable_ff) begin
         if (run_step >= debounce_ff) begin
            stable_in  = det;
            changed_in = 1'b1;
         end else begin
            run_in = run_step;
         end
      end
   end

   // climate hold and per-poll flags
   logic                     clim_valid_ff;
   logic [HUM_W-1:0]         hum_held_ff;
   logic signed [TEMP_W-1:0] tmp_held_ff;
   logic [GATE_N-1:0]        fired_ff;
   logic                     clim_fail_ff, changed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flame_raw_ff  <= 1'b0;
         stable_ff     <= 1'b0;
         pending_ff    <= 1'b0;
         run_ff        <= '0;
         clim_valid_ff <= 1'b0;
         hum_held_ff   <= '0;
         tmp_held_ff   <= '0;
         fired_ff      <= '0;
         clim_fail_ff  <= 1'b0;
         changed_ff    <= 1'b0;
      end else if (state_ff == ST_UPD) begin
         fired_ff     <= fire;
         clim_fail_ff <= fire[GATE_CLIM] & ~cok_ff;
         changed_ff   <= fire[GATE_FLAME] & changed_in;
         if (fire[GATE_FLAME]) begin
            flame_raw_ff <= det;
            stable_ff    <= stable_in;
            pending_ff   <= pending_in;
            run_ff       <= run_in;
         end
         if (fire[GATE_CLIM] && cok_ff) begin
            clim_valid_ff <= 1'b1;
            hum_held_ff   <= hum_ff;
            tmp_held_ff   <= tmp_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ch.gas_sampled       <= fired_ff[GATE_GAS];
         rsp_ch.gas_raw           <= gas_raw_ff;
         rsp_ch.gas_average       <= mean_ff;
         rsp_ch.flame_sampled     <= fired_ff[GATE_FLAME];
         rsp_ch.flame_raw         <= flame_raw_ff;
         rsp_ch.flame_stable      <= stable_ff;
         rsp_ch.flame_changed     <= changed_ff;
         rsp_ch.climate_attempted <= fired_ff[GATE_CLIM];
         rsp_ch.climate_failed    <= clim_fail_ff;
         rsp_ch.climate_usable    <= clim_valid_ff;
         rsp_ch.humidity_out      <= hum_held_ff;
         rsp_ch.temperature_out   <= tmp_held_ff;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("gas window fill beyond depth");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < fill_ff)
      else $error("divider remainder not below divisor");

   a_debounce_run: assert property (@(posedge clock) disable iff (reset)
      (run_ff == '0) == (pending_ff == stable_ff))
      else $error("pending run inconsistent with pending state");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ch.ready && state_ff == ST_CMP && pos_ff == '0)
      else $error("poll taken without starting the gate pass");
`endif

endmodule

`default_nettype wire
